// ===== rtl/spq_pkg.sv =====
// Shared constants, codes and control types of the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int OCC_W    = 4;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DELETE  = 2'd1;
    localparam logic [1:0] OP_DISPLAY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Where the id and priority of a result beat come from.
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_HEAD = 2'd1;
    localparam logic [1:0] SRC_IDX  = 2'd2;

    typedef struct packed {
        logic       do_insert;
        logic       do_delete;
        logic       disp_start;
        logic       load;
        logic [1:0] src;
        logic [1:0] status;
    } t_spq_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic disp_last;
    } t_spq_stat;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
module spq_ctrl import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_spq_stat  i_stat,
    output t_spq_cmd   o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DISP = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = w_out_free;
                if (i_in_valid && w_out_free) begin
                    case (i_op)
                        OP_INSERT: begin
                            o_cmd.load      = 1'b1;
                            o_cmd.src       = SRC_ZERO;
                            o_cmd.status    = i_stat.full ? ST_OVERFLOW : ST_OK;
                            o_cmd.do_insert = !i_stat.full;
                        end
                        OP_DELETE: begin
                            o_cmd.load      = 1'b1;
                            o_cmd.src       = i_stat.empty ? SRC_ZERO : SRC_HEAD;
                            o_cmd.status    = i_stat.empty ? ST_UNDERFLOW : ST_OK;
                            o_cmd.do_delete = !i_stat.empty;
                        end
                        OP_DISPLAY: begin
                            if (i_stat.empty) begin
                                o_cmd.load   = 1'b1;
                                o_cmd.src    = SRC_ZERO;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.disp_start = 1'b1;
                                n_state          = ST_DISP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DISP: begin
                if (w_out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.src    = SRC_IDX;
                    o_cmd.status = ST_OK;
                    if (i_stat.disp_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> w_out_free)
        else $error("result loaded over a beat not yet taken");

    a_disp_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.disp_start |=> (r_state == ST_DISP))
        else $error("display start did not enter the display walk");

    a_disp_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DISP && o_cmd.load && i_stat.disp_last) |=> (r_state == ST_IDLE))
        else $error("display walk ran past the last entry");

endmodule

// ===== rtl/spq_dpath.sv =====
// Datapath of the sorted priority queue: sorted shift chain, count, walk index, result register.
module spq_dpath import spq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_spq_cmd          i_cmd,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [PRIO_W-1:0] i_job_prio,
    output t_spq_stat         o_stat,
    output logic [1:0]        o_status,
    output logic [ID_W-1:0]   o_id,
    output logic [PRIO_W-1:0] o_prio,
    output logic [OCC_W-1:0]  o_occ,
    output logic              o_last
);

    logic [PRIO_W-1:0] r_prio [CAPACITY];
    logic [ID_W-1:0]   r_id   [CAPACITY];
    logic [CAPACITY-1:0] w_keep;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx;
    logic              w_disp_last;

    // A cell stays put on insert when it holds a job that sorts ahead of the new one.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_keep[i] = (CNT_W'(i) < r_count) && (r_prio[i] <= i_job_prio);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.do_insert && !w_keep[g]) begin
                if (g == 0) begin
                    r_prio[g] <= i_job_prio;
                    r_id[g]   <= i_job_id;
                end else if (w_keep[(g == 0) ? 0 : g-1]) begin
                    r_prio[g] <= i_job_prio;
                    r_id[g]   <= i_job_id;
                end else begin
                    r_prio[g] <= r_prio[(g == 0) ? 0 : g-1];
                    r_id[g]   <= r_id[(g == 0) ? 0 : g-1];
                end
            end else if (i_cmd.do_delete && g < CAPACITY - 1) begin
                r_prio[g] <= r_prio[(g < CAPACITY - 1) ? g+1 : g];
                r_id[g]   <= r_id[(g < CAPACITY - 1) ? g+1 : g];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.do_delete) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_disp_last      = (CNT_W'(r_idx) == r_count - 1'b1);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(CAPACITY));
    assign o_stat.disp_last = w_disp_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.disp_start) begin
            r_idx <= '0;
        end else if (i_cmd.load && i_cmd.src == SRC_IDX && !w_disp_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_status <= i_cmd.status;
            o_occ    <= OCC_W'(n_count);
            unique case (i_cmd.src)
                SRC_HEAD: begin
                    o_id   <= r_id[0];
                    o_prio <= r_prio[0];
                    o_last <= 1'b1;
                end
                SRC_IDX: begin
                    o_id   <= r_id[r_idx];
                    o_prio <= r_prio[r_idx];
                    o_last <= w_disp_last;
                end
                default: begin
                    o_id   <= '0;
                    o_prio <= '0;
                    o_last <= 1'b1;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_insert |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the queue by one");

    a_one_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.do_insert && i_cmd.do_delete) && !(i_cmd.do_delete && o_stat.empty))
        else $error("conflicting edit of the entry chain");

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: stream ports around controller and datapath.
//
// The block holds up to CAPACITY jobs (16-bit id, 8-bit priority) in a register chain kept
// in ascending priority order; lower values are served first and equal priorities keep
// arrival order. Each input beat carries an operation in tuser: insert (0) places the job
// in sorted position, all cells comparing against the new priority at once and shifting
// by one behind it; delete (1) returns the head and shifts the chain forward; display (2)
// emits one beat per held entry, head first, with tlast on the final one; code 3 is
// dropped with no result. Insert, delete, an empty display and code 3 complete in the
// cycle in which their beat is taken. A new beat is taken only when the output register
// is empty or its beat leaves in the same cycle, so a stalled result holds off the input.
// A display first takes the input beat, then walks the entries, refilling the single
// output register with one entry per cycle unless the output stalls. No input beat is
// taken during that walk. Result status in tuser: 0 ok, 1 overflow on insert into a full
// queue, 2 underflow on delete from an empty queue, 3 empty on display. Occupancy is the
// count after the operation, masked to four bits.
module sorted_priority_queue_unit import spq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [15:0] job_id, [23:16] job_priority
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [15:0] out_id, [23:16] out_priority,
                                         // [27:24] occupancy, [31:28] zero
    output logic [1:0]  o_m_axis_tuser,  // [1:0] status
    output logic        o_m_axis_tlast
);

    t_spq_cmd          w_cmd;
    t_spq_stat         w_stat;
    logic [ID_W-1:0]   w_id;
    logic [PRIO_W-1:0] w_prio;
    logic [OCC_W-1:0]  w_occ;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    spq_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_job_id   (i_s_axis_tdata[15:0]),
        .i_job_prio (i_s_axis_tdata[23:16]),
        .o_stat     (w_stat),
        .o_status   (o_m_axis_tuser),
        .o_id       (w_id),
        .o_prio     (w_prio),
        .o_occ      (w_occ),
        .o_last     (o_m_axis_tlast)
    );

    // Output beat layout: id low, then priority, then occupancy, zero padded to 32 bits.
    assign o_m_axis_tdata = {4'd0, w_occ, w_prio, w_id};

endmodule
